/* design/mm4_pkg.sv */
// Package with the shared widths, types and constants of the 4x4 matrix multiplier.
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

  // Default matrix dimension.
  localparam int DIM_DEF = 4;

  // Element widths: Q8.8 operands and the Q18.16 result.
  localparam int IN_W  = 16;
  localparam int MUL_W = 2 * IN_W;
  localparam int OUT_W = 34;
  localparam int IDX_OUT_W = 2;

  // Result range; sums beyond it are clamped.
  localparam longint PROD_MAX = 64'sd8589934591;
  localparam longint PROD_MIN = -64'sd8589934592;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } seq_state_e;

  // Control word that travels down the multiply-accumulate pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Status of the output buffer as seen by the sequencer.
  typedef struct packed {
    logic capture;
    logic pending;
  } mrg_status_t;

endpackage

`default_nettype wire

/* design/mm4_store.sv */
// Element stores for both matrices with registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mm4_store
  import mm4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               wr_en_i,
  input  wire logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] wr_idx_i,
  input  wire logic [$clog2(MATRIX_DIM)-1:0]      wr_row_i,
  input  wire logic [$clog2(MATRIX_DIM)-1:0]      wr_col_i,
  input  wire logic [IN_W-1:0]                    a_wdata_i,
  input  wire logic [IN_W-1:0]                    b_wdata_i,
  input  wire mac_ctl_t                           ctl_i,
  input  wire logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] a_raddr_i,
  input  wire logic [$clog2(MATRIX_DIM)-1:0]      b_raddr_i,
  output mac_ctl_t                                ctl_o,
  output logic [IN_W-1:0]                         a_rdata_o,
  output logic [MATRIX_DIM-1:0][IN_W-1:0]         b_rdata_o
);

  localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;

  // Left matrix is kept element by element, right matrix as whole rows.
  logic [IN_W-1:0]                 a_mem [ELEMS];
  logic [MATRIX_DIM-1:0][IN_W-1:0] b_mem [MATRIX_DIM];
  logic [IN_W-1:0]                 a_rd_q;
  logic [MATRIX_DIM-1:0][IN_W-1:0] b_rd_q;
  mac_ctl_t                        ctl_q;

  // Write port: one element of each matrix per loaded beat.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      a_mem[wr_idx_i]           <= a_wdata_i;
      b_mem[wr_row_i][wr_col_i] <= b_wdata_i;
    end
  end

  // Read port: one element of A and one row of B, registered.
  always_ff @(posedge clk_i) begin
    a_rd_q <= a_mem[a_raddr_i];
    b_rd_q <= b_mem[b_raddr_i];
  end

  // The control word is registered alongside the read data, so the two stay aligned.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  assign ctl_o     = ctl_q;
  assign a_rdata_o = a_rd_q;
  assign b_rdata_o = b_rd_q;

endmodule

`default_nettype wire

/* design/mm4_lane.sv */
// One multiply-accumulate lane that builds one column of the current product row.
`timescale 1ns / 1ps
`default_nettype none

module mm4_lane
  import mm4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire mac_ctl_t                                  ctl_i,
  input  wire logic [IN_W-1:0]                           a_i,
  input  wire logic [IN_W-1:0]                           b_i,
  output logic                                           done_o,
  output logic [MUL_W+$clog2(MATRIX_DIM)+2-1:0]          acc_o
);

  localparam int ACC_W = MUL_W + $clog2(MATRIX_DIM) + 2;

  mac_ctl_t                 ctl_q;
  logic                     done_q;
  logic signed [MUL_W-1:0]  prod_d;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;

  // Signed 16x16 product, registered before the adder.
  assign prod_d = $signed(a_i) * $signed(b_i);

  // The first term of a row restarts the sum.
  always_comb begin
    if (ctl_q.first) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // Control pipeline; done marks a finished row sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_q <= ctl_q.valid & ctl_q.last;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

/* design/mm4_merge.sv */
// Merging stage: clamps the lane sums of a row and sends them out one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module mm4_merge
  import mm4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              done_i,
  input  wire logic [MATRIX_DIM-1:0][MUL_W+$clog2(MATRIX_DIM)+2-1:0] acc_i,
  output mrg_status_t                                            status_o,
  output logic                                                   out_valid_o,
  input  wire logic                                              out_stall_i,
  output logic [OUT_W-1:0]                                       product_value_o,
  output logic [IDX_OUT_W-1:0]                                   row_index_o,
  output logic [IDX_OUT_W-1:0]                                   col_index_o,
  output logic                                                   last_o
);

  localparam int ACC_W = MUL_W + $clog2(MATRIX_DIM) + 2;
  localparam int IDX_W = $clog2(MATRIX_DIM);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(PROD_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(PROD_MIN);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(MATRIX_DIM - 1);

  logic [OUT_W-1:0] sat_d [MATRIX_DIM];
  logic [OUT_W-1:0] buf_q [MATRIX_DIM];
  logic             pend_q;
  logic             occ_q;
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;
  logic             capture;
  logic             take;

  // Clamp each lane sum to the result range.
  always_comb begin
    for (int j = 0; j < MATRIX_DIM; j++) begin
      if ($signed(acc_i[j]) > SAT_HI) begin
        sat_d[j] = OUT_W'(SAT_HI);
      end else if ($signed(acc_i[j]) < SAT_LO) begin
        sat_d[j] = OUT_W'(SAT_LO);
      end else begin
        sat_d[j] = acc_i[j][OUT_W-1:0];
      end
    end
  end

  // A finished row moves into the buffer once the previous row has left.
  assign capture = pend_q & ~occ_q;
  assign take    = occ_q & ~out_stall_i;

  always_ff @(posedge clk_i) begin
    if (capture) begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
        buf_q[j] <= sat_d[j];
      end
    end
  end

  // Buffer occupancy, row and column counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      occ_q  <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      if (done_i) begin
        pend_q <= 1'b1;
      end else if (capture) begin
        pend_q <= 1'b0;
      end
      if (capture) begin
        occ_q <= 1'b1;
      end else if (take && col_q == IDX_END) begin
        occ_q <= 1'b0;
      end
      if (take) begin
        if (col_q == IDX_END) begin
          col_q <= '0;
          row_q <= (row_q == IDX_END) ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  assign status_o.capture = capture;
  assign status_o.pending = pend_q;

  assign out_valid_o     = occ_q;
  assign product_value_o = buf_q[col_q];
  assign row_index_o     = IDX_OUT_W'(row_q);
  assign col_index_o     = IDX_OUT_W'(col_q);
  assign last_o          = (row_q == IDX_END) && (col_q == IDX_END);

endmodule

`default_nettype wire

/* design/matrix_multiply_4x4_top.sv */
// Top level of the fixed-point square matrix multiplier C = A * B.
//
// Input channel: each beat carries one element of A and the element of B at
// the same position, in row-major order, as signed Q8.8. A beat is taken
// whenever the block is loading; in_stall_o is high during compute.
// After the last of the MATRIX_DIM*MATRIX_DIM pairs, one lane per column
// forms a whole row of C: MATRIX_DIM reads of the shared store port, then
// the store read register, the product register, the accumulator and a
// handoff into the output buffer. The read port of the left-matrix store,
// one element per cycle, sets the pace of each row.
// With MATRIX_DIM = 4 a matrix pair is sixteen input beats; the last row
// of C drains while the next pair is loading.
// Output channel: the elements of C come in row-major order as Q18.16 with
// row and column tags; last_o marks the final element. When the receiver
// stalls, the beat holds and the row after it waits in the lanes.
// Reset clears the load counter and all control state; the stores are not
// cleared since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_4x4_top
  import mm4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [IN_W-1:0]       a_value_i,
  input  wire logic [IN_W-1:0]       b_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [OUT_W-1:0]           product_value_o,
  output logic [IDX_OUT_W-1:0]       row_index_o,
  output logic [IDX_OUT_W-1:0]       col_index_o,
  output logic                       last_o
);

  localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;
  localparam int CNT_W = $clog2(ELEMS);
  localparam int IDX_W = $clog2(MATRIX_DIM);
  localparam int ACC_W = MUL_W + $clog2(MATRIX_DIM) + 2;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ELEMS - 1);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(MATRIX_DIM - 1);

  seq_state_e state_q, state_d;
  logic [CNT_W-1:0] load_idx_q, load_idx_d;
  logic [IDX_W-1:0] load_row_q, load_row_d;
  logic [IDX_W-1:0] load_col_q, load_col_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic             in_take;
  mac_ctl_t         iss_ctl;
  logic [CNT_W-1:0] a_raddr;

  mac_ctl_t                        rd_ctl;
  logic [IN_W-1:0]                 a_rdata;
  logic [MATRIX_DIM-1:0][IN_W-1:0] b_rdata;
  logic [MATRIX_DIM-1:0]           lane_done;
  logic [MATRIX_DIM-1:0][ACC_W-1:0] lane_acc;
  mrg_status_t                     mrg_status;

  assign in_take = in_valid_i & ~in_stall_o;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_take && load_idx_q == CNT_END) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == IDX_END) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mrg_status.capture) begin
          state_d = (row_q == IDX_END) ? ST_LOAD : ST_ISSUE;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Counter updates for loading and for row issue.
  always_comb begin
    load_idx_d = load_idx_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    row_d      = row_q;
    k_d        = k_q;
    if (in_take) begin
      if (load_idx_q == CNT_END) begin
        load_idx_d = '0;
        load_row_d = '0;
        load_col_d = '0;
      end else begin
        load_idx_d = load_idx_q + 1'b1;
        if (load_col_q == IDX_END) begin
          load_col_d = '0;
          load_row_d = load_row_q + 1'b1;
        end else begin
          load_col_d = load_col_q + 1'b1;
        end
      end
    end
    if (state_q == ST_ISSUE) begin
      k_d = (k_q == IDX_END) ? '0 : k_q + 1'b1;
    end
    if (state_q == ST_WAIT && mrg_status.capture) begin
      row_d = (row_q == IDX_END) ? '0 : row_q + 1'b1;
    end
  end

  // Output logic of the sequencer.
  always_comb begin
    in_stall_o    = 1'b1;
    iss_ctl       = '0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
      end
      ST_ISSUE: begin
        iss_ctl.valid = 1'b1;
        iss_ctl.first = (k_q == '0);
        iss_ctl.last  = (k_q == IDX_END);
      end
      ST_WAIT: begin
        in_stall_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign a_raddr = CNT_W'(row_q * MATRIX_DIM) + CNT_W'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_idx_q <= '0;
      load_row_q <= '0;
      load_col_q <= '0;
      row_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      row_q      <= row_d;
      k_q        <= k_d;
    end
  end

  // Matrix stores.
  mm4_store #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_take),
    .wr_idx_i  (load_idx_q),
    .wr_row_i  (load_row_q),
    .wr_col_i  (load_col_q),
    .a_wdata_i (a_value_i),
    .b_wdata_i (b_value_i),
    .ctl_i     (iss_ctl),
    .a_raddr_i (a_raddr),
    .b_raddr_i (k_q),
    .ctl_o     (rd_ctl),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata)
  );

  // One lane per column of the product row.
  for (genvar j = 0; j < MATRIX_DIM; j++) begin : g_lane
    mm4_lane #(
      .MATRIX_DIM(MATRIX_DIM)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (rd_ctl),
      .a_i    (a_rdata),
      .b_i    (b_rdata[j]),
      .done_o (lane_done[j]),
      .acc_o  (lane_acc[j])
    );
  end

  // Output buffer and serializer.
  mm4_merge #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .done_i          (lane_done[0]),
    .acc_i           (lane_acc),
    .status_o        (mrg_status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .product_value_o (product_value_o),
    .row_index_o     (row_index_o),
    .col_index_o     (col_index_o),
    .last_o          (last_o)
  );

`ifndef NO_ASSERTIONS
  // A row finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> state_q == ST_WAIT)
    else $error("row finished outside the wait state");

  // All lanes finish their row in the same cycle.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> (&lane_done))
    else $error("lanes out of step");

  // Nothing follows the final element until a new pair is loaded.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !out_stall_i |=> !out_valid_o)
    else $error("output after the final element");

  // While loading, no finished row may still wait for the buffer.
  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> !mrg_status.pending)
    else $error("pending row during load");
`endif

endmodule

`default_nettype wire

/* tb/mm4_product_checker.sv */
// Checker that predicts the product matrix from the input beats and compares each output beat.
`timescale 1ns / 1ps

module mm4_product_checker
  import mm4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic [IN_W-1:0]      a_value_i,
  input  wire logic [IN_W-1:0]      b_value_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic [OUT_W-1:0]     product_value_i,
  input  wire logic [IDX_OUT_W-1:0] row_index_i,
  input  wire logic [IDX_OUT_W-1:0] col_index_i,
  input  wire logic                 last_i,
  output int                        outstanding_o,
  output int                        fail_count_o
);

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int REPORT_LIMIT = 10;

  // One element of the product matrix as it appears on the output channel.
  typedef struct packed {
    logic [OUT_W-1:0]     value;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last;
  } product_beat_t;

  // Shadow copies of the two operand matrices and the load position.
  logic signed [IN_W-1:0] left_shadow  [ELEM_COUNT];
  logic signed [IN_W-1:0] right_shadow [ELEM_COUNT];
  int                     pairs_loaded;

  product_beat_t product_queue [$];
  product_beat_t expected_beat;
  product_beat_t actual_beat;
  int            mismatches;

  // Exact sum of products for one element, clamped to the result range.
  function automatic logic [OUT_W-1:0] element_sum(int row, int col);
    longint acc;
    acc = 0;
    for (int k = 0; k < MATRIX_DIM; k++) begin
      acc += longint'(left_shadow[row * MATRIX_DIM + k]) *
             longint'(right_shadow[k * MATRIX_DIM + col]);
    end
    if (acc > PROD_MAX) acc = PROD_MAX;
    if (acc < PROD_MIN) acc = PROD_MIN;
    return acc[OUT_W-1:0];
  endfunction

  // Load the shadow matrices, predict a full product on the final pair,
  // and compare every accepted output beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_loaded = 0;
      mismatches = 0;
      product_queue.delete();
      outstanding_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        left_shadow[pairs_loaded] = a_value_i;
        right_shadow[pairs_loaded] = b_value_i;
        pairs_loaded++;
        if (pairs_loaded == ELEM_COUNT) begin
          for (int r = 0; r < MATRIX_DIM; r++) begin
            for (int c = 0; c < MATRIX_DIM; c++) begin
              expected_beat.value = element_sum(r, c);
              expected_beat.row = r[IDX_OUT_W-1:0];
              expected_beat.col = c[IDX_OUT_W-1:0];
              expected_beat.last = (r == MATRIX_DIM - 1) && (c == MATRIX_DIM - 1);
              product_queue.push_back(expected_beat);
            end
          end
          pairs_loaded = 0;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        actual_beat = '{product_value_i, row_index_i, col_index_i, last_i};
        if (product_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected beat value %0d row %0d col %0d last %0d", $realtime,
                     $signed(actual_beat.value), actual_beat.row, actual_beat.col,
                     actual_beat.last);
          end
        end else begin
          expected_beat = product_queue.pop_front();
          if (expected_beat != actual_beat) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mismatch, expected value %0d row %0d col %0d last %0d",
                       $realtime, $signed(expected_beat.value), expected_beat.row,
                       expected_beat.col, expected_beat.last);
              $display("%0t:           actual value %0d row %0d col %0d last %0d",
                       $realtime, $signed(actual_beat.value), actual_beat.row,
                       actual_beat.col, actual_beat.last);
            end
          end
        end
      end

      outstanding_o <= product_queue.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: drives matrix pairs into the multiplier, stalls its output and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
  import mm4_pkg::*;

  localparam int MATRIX_DIM = DIM_DEF;
  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int RANDOM_MATRICES = 9;
  localparam int MAX_GAP = 14;
  localparam int DRAIN_CYCLES = 2 * (MATRIX_DIM + 5);

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [IN_W-1:0]      a_value = '0;
  logic [IN_W-1:0]      b_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic [OUT_W-1:0]     product_value;
  logic [IDX_OUT_W-1:0] row_index;
  logic [IDX_OUT_W-1:0] col_index;
  logic                 last;
  int                   outstanding;
  int                   fail_count;
  bit                   feed_burst;

  // Row patterns of A and column patterns of B for the directed matrix.
  logic [IN_W-1:0] a_row_pattern [MATRIX_DIM];
  logic [IN_W-1:0] b_col_pattern [MATRIX_DIM];

  always #1 clk_i = ~clk_i;

  matrix_multiply_4x4_top #(
    .MATRIX_DIM(MATRIX_DIM)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .a_value_i      (a_value),
    .b_value_i      (b_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .product_value_o(product_value),
    .row_index_o    (row_index),
    .col_index_o    (col_index),
    .last_o         (last)
  );

  mm4_product_checker #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .a_value_i      (a_value),
    .b_value_i      (b_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .product_value_i(product_value),
    .row_index_i    (row_index),
    .col_index_i    (col_index),
    .last_i         (last),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count)
  );

  // Pick one operand element in the style chosen for the matrix.
  function automatic logic [IN_W-1:0] draw_element(int style);
    int pick;
    pick = (style == 3) ? $urandom_range(0, 2) : style;
    case (pick)
      0: return IN_W'($urandom_range(0, 16'hFFFF));
      1: return IN_W'($signed($urandom_range(0, 1023)) - 512);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  // Present one pair of elements after a random gap and hold it until taken.
  task automatic send_pair(input logic [IN_W-1:0] a_elem, input logic [IN_W-1:0] b_elem);
    int gap;
    gap = feed_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    a_value <= a_elem;
    b_value <= b_elem;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Output side: stall for a random number of cycles, then take one beat.
  initial begin : output_stall_driver
    int hold;
    int beats;
    bit drain_burst;
    beats = 0;
    drain_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (beats % ELEM_COUNT == 0) drain_burst = ($urandom_range(0, 3) == 0);
      hold = drain_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      beats++;
    end
  end

  // Stimulus: one directed matrix pair with the extreme values, then random pairs.
  initial begin : stimulus
    int style;
    a_row_pattern = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
    b_col_pattern = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h5A5A};
    feed_burst = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rows of A against columns of B give the largest positive and
    // negative sums, sign flips through minus one, and zero rows.
    for (int e = 0; e < ELEM_COUNT; e++) begin
      send_pair(a_row_pattern[e / MATRIX_DIM], b_col_pattern[e % MATRIX_DIM]);
    end

    for (int m = 0; m < RANDOM_MATRICES; m++) begin
      feed_burst = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 3);
      for (int e = 0; e < ELEM_COUNT; e++) begin
        send_pair(draw_element(style), draw_element(style));
      end
    end
    in_valid <= 1'b0;

    // Let the checker count the predictions of the final pair first.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
